// File: src/sobel_pkg.sv
package sobel_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W  = 8;
    localparam int COL_W  = 10;
    localparam int ROW_W  = 12;
    localparam int WID_W  = 11;
    localparam int HGT_W  = 13;
    localparam int LUMA_W = 24;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = HGT_W;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [15:0] LUMA_R = 16'd19595;
    localparam logic [15:0] LUMA_G = 16'd38470;
    localparam logic [15:0] LUMA_B = 16'd7471;

    localparam int ROOT_STEPS = 8;
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
    } t_tag;

    typedef struct packed {
        logic [PIX_W-1:0] mag;
        t_tag             tag;
    } t_result;

endpackage

// File: src/sobel_ram.sv
module sobel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/sobel_edge_magnitude.sv
// Streaming 3x3 Sobel edge magnitude on RGB pixels in raster order.
// Input channel: i_valid / o_stall with i_red, i_green, i_blue; one pixel per
// transaction. Output channel: o_valid / i_stall with the magnitude, the
// column and row of the window centre and a frame-end flag.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0: image width, 1: image height); write only while the block is idle.
// Throughput: one pixel per clock while o_stall is low. The line buffer is one
// 1024 x 16 RAM that holds both previous rows; each pixel does one read at
// accept and one write-back the next cycle, always to different columns.
// Pipeline: gray and RAM read, window, kernels, squares, sum, 8 square-root
// steps, 16-entry output queue. Border pixels give no result.
// o_stall rises when the queue plus everything in flight reaches 16, so a
// stalled receiver holds back the source after at most 16 transactions that
// give a result; the head result stays steady while i_stall is high.
// Reset: counters restart at row 0 column 0, the queue empties, width and
// height return to 1024. The RAM is not cleared; a frame overwrites the two
// rows it reads before it reads them.
module sobel_edge_magnitude (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [sobel_pkg::PIX_W-1:0]       i_red,
    input  logic [sobel_pkg::PIX_W-1:0]       i_green,
    input  logic [sobel_pkg::PIX_W-1:0]       i_blue,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [sobel_pkg::PIX_W-1:0]       o_edge_magnitude,
    output logic [sobel_pkg::COL_W-1:0]       o_out_column,
    output logic [sobel_pkg::ROW_W-1:0]       o_out_row,
    output logic                              o_frame_last,
    input  logic                              i_cfg_we,
    input  logic [sobel_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sobel_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    import sobel_pkg::*;

    logic [WID_W-1:0] r_image_width;
    logic [HGT_W-1:0] r_image_height;
    logic [WID_W-1:0] w_width;
    logic [HGT_W-1:0] w_height;

    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic             w_acc;
    logic             w_row_end;
    logic             w_frame_end;
    logic [LUMA_W-1:0] w_luma;

    logic             r_s0_valid;
    logic             r_s0_emit;
    logic [PIX_W-1:0] r_s0_gray;
    logic [COL_W-1:0] r_s0_col;
    logic [ROW_W-1:0] r_s0_row;
    logic             r_s0_last;

    logic [2*PIX_W-1:0] w_ram_rdata;
    logic [PIX_W-1:0]   w_top;
    logic [PIX_W-1:0]   w_mid;

    logic [PIX_W-1:0] r_win [9];
    logic             r_s1_valid;
    t_tag             r_s1_tag;

    logic [9:0]        w_gx_pos;
    logic [9:0]        w_gx_neg;
    logic [9:0]        w_gy_pos;
    logic [9:0]        w_gy_neg;
    logic signed [11:0] w_gx;
    logic signed [11:0] w_gy;
    logic signed [10:0] r_s2_gx;
    logic signed [10:0] r_s2_gy;
    logic              r_s2_valid;
    t_tag              r_s2_tag;

    logic signed [21:0] w_gx2;
    logic signed [21:0] w_gy2;
    logic [19:0]        r_s3_gx2;
    logic [19:0]        r_s3_gy2;
    logic               r_s3_valid;
    t_tag               r_s3_tag;

    logic [20:0] w_sum;
    logic [15:0] r_s4_x;
    logic        r_s4_sat;
    logic        r_s4_valid;
    t_tag        r_s4_tag;

    logic        r_rt_valid [ROOT_STEPS];
    logic [8:0]  r_rt_rem   [ROOT_STEPS];
    logic [7:0]  r_rt_root  [ROOT_STEPS];
    logic [15:0] r_rt_x     [ROOT_STEPS];
    logic        r_rt_sat   [ROOT_STEPS];
    t_tag        r_rt_tag   [ROOT_STEPS];
    logic [8:0]  n_rt_rem   [ROOT_STEPS];
    logic [7:0]  n_rt_root  [ROOT_STEPS];
    logic [15:0] n_rt_x     [ROOT_STEPS];

    t_result          r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_fifo_cnt;
    logic [FIFO_AW:0]   r_used;
    logic [FIFO_AW:0]   n_used;
    logic               w_push;
    logic               w_pop;
    logic               w_drop;
    t_result            w_push_data;
    t_result            w_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= WID_W'(MAX_WIDTH);
            r_image_height <= HGT_W'(1024);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[WID_W-1:0];
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[HGT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_image_width < WID_W'(3)) begin
            w_width = WID_W'(3);
        end else if (r_image_width > WID_W'(MAX_WIDTH)) begin
            w_width = WID_W'(MAX_WIDTH);
        end else begin
            w_width = r_image_width;
        end
        if (r_image_height < HGT_W'(3)) begin
            w_height = HGT_W'(3);
        end else if (r_image_height > HGT_W'(MAX_HEIGHT)) begin
            w_height = HGT_W'(MAX_HEIGHT);
        end else begin
            w_height = r_image_height;
        end
    end

    assign w_acc       = i_valid & ~o_stall;
    assign w_row_end   = (WID_W'(r_col) + WID_W'(1)) >= w_width;
    assign w_frame_end = w_row_end && ((HGT_W'(r_row) + HGT_W'(1)) >= w_height);
    assign w_luma      = LUMA_W'(LUMA_R) * LUMA_W'(i_red)
                       + LUMA_W'(LUMA_G) * LUMA_W'(i_green)
                       + LUMA_W'(LUMA_B) * LUMA_W'(i_blue);

    // advance position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_acc) begin
            if (w_row_end) begin
                r_col <= '0;
                r_row <= w_frame_end ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else begin
            r_s0_valid <= w_acc;
        end
        if (w_acc) begin
            r_s0_gray <= w_luma[LUMA_W-1 -: PIX_W];
            r_s0_col  <= r_col;
            r_s0_row  <= r_row;
            r_s0_last <= w_frame_end;
            r_s0_emit <= (r_col >= COL_W'(2)) && (r_row >= ROW_W'(2));
        end
    end

    sobel_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_s0_valid),
        .i_waddr (r_s0_col),
        .i_wdata ({w_mid, r_s0_gray}),
        .i_re    (w_acc),
        .i_raddr (r_col),
        .o_rdata (w_ram_rdata)
    );

    assign w_top = w_ram_rdata[2*PIX_W-1:PIX_W];
    assign w_mid = w_ram_rdata[PIX_W-1:0];

    // shift window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= r_s0_valid & r_s0_emit;
            if (r_s0_valid) begin
                for (int k = 0; k < 3; k++) begin
                    r_win[k*3]   <= r_win[k*3+1];
                    r_win[k*3+1] <= r_win[k*3+2];
                end
                r_win[2] <= w_top;
                r_win[5] <= w_mid;
                r_win[8] <= r_s0_gray;
            end
        end
        if (r_s0_valid) begin
            r_s1_tag.col  <= r_s0_col - COL_W'(1);
            r_s1_tag.row  <= r_s0_row - ROW_W'(1);
            r_s1_tag.last <= r_s0_last;
        end
    end

    assign w_gx_pos = 10'(r_win[2]) + 10'({r_win[5], 1'b0}) + 10'(r_win[8]);
    assign w_gx_neg = 10'(r_win[0]) + 10'({r_win[3], 1'b0}) + 10'(r_win[6]);
    assign w_gy_pos = 10'(r_win[6]) + 10'({r_win[7], 1'b0}) + 10'(r_win[8]);
    assign w_gy_neg = 10'(r_win[0]) + 10'({r_win[1], 1'b0}) + 10'(r_win[2]);
    assign w_gx     = $signed({2'b00, w_gx_pos}) - $signed({2'b00, w_gx_neg});
    assign w_gy     = $signed({2'b00, w_gy_pos}) - $signed({2'b00, w_gy_neg});
    assign w_gx2    = r_s2_gx * r_s2_gx;
    assign w_gy2    = r_s2_gy * r_s2_gy;
    assign w_sum    = 21'(r_s3_gx2) + 21'(r_s3_gy2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
        r_s2_gx  <= w_gx[10:0];
        r_s2_gy  <= w_gy[10:0];
        r_s2_tag <= r_s1_tag;
        r_s3_gx2 <= w_gx2[19:0];
        r_s3_gy2 <= w_gy2[19:0];
        r_s3_tag <= r_s2_tag;
        r_s4_x   <= w_sum[15:0];
        r_s4_sat <= |w_sum[20:16];
        r_s4_tag <= r_s3_tag;
    end

    // one root bit per stage
    always_comb begin
        logic [8:0]  src_rem;
        logic [7:0]  src_root;
        logic [15:0] src_x;
        logic [10:0] shifted;
        logic [10:0] trial;
        for (int k = 0; k < ROOT_STEPS; k++) begin
            if (k == 0) begin
                src_rem  = '0;
                src_root = '0;
                src_x    = r_s4_x;
            end else begin
                src_rem  = r_rt_rem[k-1];
                src_root = r_rt_root[k-1];
                src_x    = r_rt_x[k-1];
            end
            shifted = {src_rem, src_x[15:14]};
            trial   = {1'b0, src_root, 2'b01};
            if (shifted >= trial) begin
                n_rt_rem[k]  = 9'(shifted - trial);
                n_rt_root[k] = {src_root[6:0], 1'b1};
            end else begin
                n_rt_rem[k]  = shifted[8:0];
                n_rt_root[k] = {src_root[6:0], 1'b0};
            end
            n_rt_x[k] = {src_x[13:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ROOT_STEPS; k++) begin
                r_rt_valid[k] <= 1'b0;
            end
        end else begin
            r_rt_valid[0] <= r_s4_valid;
            for (int k = 1; k < ROOT_STEPS; k++) begin
                r_rt_valid[k] <= r_rt_valid[k-1];
            end
        end
        for (int k = 0; k < ROOT_STEPS; k++) begin
            r_rt_rem[k]  <= n_rt_rem[k];
            r_rt_root[k] <= n_rt_root[k];
            r_rt_x[k]    <= n_rt_x[k];
        end
        r_rt_sat[0] <= r_s4_sat;
        r_rt_tag[0] <= r_s4_tag;
        for (int k = 1; k < ROOT_STEPS; k++) begin
            r_rt_sat[k] <= r_rt_sat[k-1];
            r_rt_tag[k] <= r_rt_tag[k-1];
        end
    end

    assign w_push          = r_rt_valid[ROOT_STEPS-1];
    assign w_push_data.mag = r_rt_sat[ROOT_STEPS-1] ? {PIX_W{1'b1}} : r_rt_root[ROOT_STEPS-1];
    assign w_push_data.tag = r_rt_tag[ROOT_STEPS-1];
    assign w_drop          = r_s0_valid & ~r_s0_emit;
    assign w_pop           = o_valid & ~i_stall;
    assign n_used          = r_used + (FIFO_AW+1)'(w_acc) - (FIFO_AW+1)'(w_drop)
                           - (FIFO_AW+1)'(w_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fifo_cnt <= '0;
            r_used     <= '0;
        end else begin
            r_used <= n_used;
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_fifo_cnt <= r_fifo_cnt + (FIFO_AW+1)'(w_push) - (FIFO_AW+1)'(w_pop);
        end
        if (w_push) begin
            r_fifo[r_wr_ptr] <= w_push_data;
        end
    end

    assign w_head           = r_fifo[r_rd_ptr];
    assign o_valid          = r_fifo_cnt != '0;
    assign o_stall          = ~i_rst_n | (r_used >= (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_edge_magnitude = w_head.mag;
    assign o_out_column     = w_head.tag.col;
    assign o_out_row        = w_head.tag.row;
    assign o_frame_last     = w_head.tag.last;

    a_queue_within_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fifo_cnt <= r_used)
        else $error("output queue holds more than the outstanding count");

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("outstanding count exceeds queue depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (r_fifo_cnt < (FIFO_AW+1)'(FIFO_DEPTH)) || w_pop)
        else $error("push into a full output queue");

    a_ram_columns_differ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && r_s0_valid) |-> (r_col != r_s0_col))
        else $error("line RAM read and write-back hit the same column");

endmodule

// File: verif/tb_sobel_edge_magnitude.sv
module tb_sobel_edge_magnitude;
    import sobel_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int LIMIT_CYCLES  = 300000;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_ITEMS  = 500;
    localparam int SCRIPT_LEN    = 18;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [PIX_W-1:0]      i_red;
    logic [PIX_W-1:0]      i_green;
    logic [PIX_W-1:0]      i_blue;
    logic                  o_valid;
    logic                  i_stall;
    logic [PIX_W-1:0]      o_edge_magnitude;
    logic [COL_W-1:0]      o_out_column;
    logic [ROW_W-1:0]      o_out_row;
    logic                  o_frame_last;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    sobel_edge_magnitude DUT (.*);

    class edge_scoreboard;
        logic [WID_W-1:0] width_reg;
        logic [HGT_W-1:0] height_reg;
        logic [7:0]       lines [2*MAX_WIDTH];
        logic [7:0]       window [9];
        int unsigned      col;
        int unsigned      row;
        t_result          edges_due [$];
        int               errors;

        function new();
            width_reg  = 11'd1024;
            height_reg = 13'd1024;
            foreach (lines[i]) lines[i] = '0;
            foreach (window[i]) window[i] = '0;
            col    = 0;
            row    = 0;
            errors = 0;
        endfunction

        function int unsigned clamp_dim(int unsigned v, int unsigned top);
            if (v < 3) return 3;
            if (v > top) return top;
            return v;
        endfunction

        function int unsigned cur_width();
            return clamp_dim(32'(width_reg), MAX_WIDTH);
        endfunction

        function int unsigned cur_height();
            return clamp_dim(32'(height_reg), MAX_HEIGHT);
        endfunction

        function bit at_frame_start();
            return col == 0 && row == 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            if (index == REG_IMAGE_WIDTH) begin
                width_reg = data[WID_W-1:0];
            end else begin
                height_reg = data[HGT_W-1:0];
            end
        endfunction

        function int pixels_left();
            int unsigned c, r, w, h;
            int n;
            bit done;
            c = col;
            r = row;
            w = cur_width();
            h = cur_height();
            n = 0;
            done = 0;
            while (!done) begin
                n++;
                if (c + 1 >= w) begin
                    done = (r + 1 >= h);
                    c = 0;
                    r = r + 1;
                end else begin
                    c++;
                end
            end
            return n;
        endfunction

        function logic [7:0] edge_root(int unsigned s);
            int unsigned r, c;
            if (s >= 65536) return 8'd255;
            r = 0;
            for (int b = 7; b >= 0; b--) begin
                c = r | (1 << b);
                if (c * c <= s) r = c;
            end
            return r[7:0];
        endfunction

        function void accept_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
            int unsigned w, h, gray, idx, sq;
            logic [7:0]  above, beside;
            bit          row_end, frame_end;
            int          gx, gy;
            t_result     res;
            w = cur_width();
            h = cur_height();
            gray = (32'(LUMA_R) * red + 32'(LUMA_G) * green + 32'(LUMA_B) * blue) >> 16;
            idx = (col < MAX_WIDTH) ? col : MAX_WIDTH - 1;
            row_end = (col + 1 >= w);
            frame_end = row_end && (row + 1 >= h);
            above = lines[MAX_WIDTH + idx];
            beside = lines[idx];
            lines[MAX_WIDTH + idx] = beside;
            lines[idx] = gray[7:0];
            for (int k = 0; k < 3; k++) begin
                window[k*3]   = window[k*3+1];
                window[k*3+1] = window[k*3+2];
            end
            window[2] = above;
            window[5] = beside;
            window[8] = gray[7:0];
            if (col >= 2 && row >= 2) begin
                gx = -int'(window[0]) + int'(window[2]) - 2 * int'(window[3])
                     + 2 * int'(window[5]) - int'(window[6]) + int'(window[8]);
                gy = -int'(window[0]) - 2 * int'(window[1]) - int'(window[2])
                     + int'(window[6]) + 2 * int'(window[7]) + int'(window[8]);
                sq = gx * gx + gy * gy;
                res.mag      = edge_root(sq);
                res.tag.col  = COL_W'(col - 1);
                res.tag.row  = ROW_W'(row - 1);
                res.tag.last = frame_end;
                edges_due.push_back(res);
            end
            if (row_end) begin
                col = 0;
                row = frame_end ? 0 : ((row + 1) & 32'hFFF);
            end else begin
                col = (col + 1) & 32'h3FF;
            end
        endfunction

        function void check_edge(logic [7:0] mag, logic [COL_W-1:0] c, logic [ROW_W-1:0] r,
                                 logic last);
            t_result want;
            if (edges_due.size() == 0) begin
                $display("%0t: unexpected result mag %0d col %0d row %0d last %0b",
                         $time, mag, c, r, last);
                errors++;
                return;
            end
            want = edges_due.pop_front();
            if (mag !== want.mag) begin
                $display("%0t: edge_magnitude expected %0d actual %0d (col %0d row %0d)",
                         $time, want.mag, mag, want.tag.col, want.tag.row);
                errors++;
            end
            if (c !== want.tag.col) begin
                $display("%0t: out_column expected %0d actual %0d", $time, want.tag.col, c);
                errors++;
            end
            if (r !== want.tag.row) begin
                $display("%0t: out_row expected %0d actual %0d", $time, want.tag.row, r);
                errors++;
            end
            if (last !== want.tag.last) begin
                $display("%0t: frame_last expected %0b actual %0b (col %0d row %0d)",
                         $time, want.tag.last, last, want.tag.col, want.tag.row);
                errors++;
            end
        endfunction
    endclass

    edge_scoreboard sb = new();

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int phase_no     = 0;
    int pixels_sent  = 0;
    int script_pos   = 0;
    logic [23:0] prev_rgb = '0;

    logic [23:0] script_pix [SCRIPT_LEN] = '{
        24'h000000, 24'h808080, 24'hFFFFFF,
        24'h000000, 24'h808080, 24'hFFFFFF,
        24'h000000, 24'h808080, 24'hFFFFFF,
        24'hFF0000, 24'h00FF00, 24'h0000FF,
        24'hFFFF00, 24'h00FFFF, 24'hFF00FF,
        24'h010203, 24'h808080, 24'hFEFEFE
    };

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("tb_sobel_edge_magnitude: errors");
        $finish;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < rx_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_stall === 1'b0) begin
                sb.accept_pixel(i_red, i_green, i_blue);
            end
            if (o_valid === 1'b1 && i_stall === 1'b0) begin
                sb.check_edge(o_edge_magnitude, o_out_column, o_out_row, o_frame_last);
            end
        end
    end

    function automatic void next_pixel(output logic [7:0] r, output logic [7:0] g,
                                       output logic [7:0] b);
        int pick;
        if (script_pos < SCRIPT_LEN) begin
            {r, g, b} = script_pix[script_pos];
            script_pos++;
            return;
        end
        pick = $urandom_range(9);
        case (pick)
            0: {r, g, b} = 24'h000000;
            1: {r, g, b} = 24'hFFFFFF;
            2, 3: {r, g, b} = prev_rgb ^ (24'($urandom) & 24'h030303);
            default: {r, g, b} = 24'($urandom);
        endcase
        prev_rgb = {r, g, b};
    endfunction

    task automatic push_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_red   <= r;
        i_green <= g;
        i_blue  <= b;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        while (sb.edges_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (sb.edges_due.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.edges_due.size());
            sb.errors++;
            sb.edges_due.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // count of zero: run to the end of the current frame
    task automatic run_phase(input bit set_w, input logic [CFG_DATA_W-1:0] w,
                             input bit set_h, input logic [CFG_DATA_W-1:0] h,
                             input int count);
        int n;
        logic [7:0] r, g, b;
        case (phase_no % 4)
            0: begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end
            1: begin
                tx_idle_pct  = 64;
                rx_stall_pct = 0;
            end
            2: begin
                tx_idle_pct  = 0;
                rx_stall_pct = 64;
            end
            default: begin
                tx_idle_pct  = 15;
                rx_stall_pct = 15;
            end
        endcase
        phase_no++;
        if (set_w) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= REG_IMAGE_WIDTH;
            i_cfg_data  <= w;
            @(posedge i_clk);
            sb.set_register(REG_IMAGE_WIDTH, w);
        end
        if (set_h) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= REG_IMAGE_HEIGHT;
            i_cfg_data  <= h;
            @(posedge i_clk);
            sb.set_register(REG_IMAGE_HEIGHT, h);
        end
        i_cfg_we <= 1'b0;
        n = (count == 0) ? sb.pixels_left() : count;
        repeat (n) begin
            next_pixel(r, g, b);
            push_pixel(r, g, b);
        end
        i_valid <= 1'b0;
        pixels_sent += n;
        drain();
    endtask

    initial begin
        int base;
        bit set_w, set_h;
        logic [CFG_DATA_W-1:0] w, h;
        int count;

        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_stall     <= 1'b0;
        i_red       <= '0;
        i_green     <= '0;
        i_blue      <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= REG_IMAGE_WIDTH;
        i_cfg_data  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // two scripted 3x3 frames: saturating edge, then one- and two-channel colours and grays
        run_phase(1, 13'd0, 1, 13'd1, SCRIPT_LEN);
        // full-width rows, width above range masked and clamped
        run_phase(1, 13'h1FFF, 1, 13'd3, 1030);
        run_phase(1, 13'd5, 1, 13'h1000, 40);
        // shrink height below the current row, then width below the column
        run_phase(0, '0, 1, 13'd4, 14);
        run_phase(1, 13'd1, 0, '0, 0);
        run_phase(1, 13'd2, 1, 13'h1FFF, 30);
        run_phase(0, '0, 1, 13'd0, 0);

        base = pixels_sent;
        while (pixels_sent - base < RANDOM_ITEMS) begin
            case ($urandom_range(15))
                0, 1: w = CFG_DATA_W'($urandom_range(2));
                2: w = CFG_DATA_W'($urandom_range(64, 17));
                default: w = CFG_DATA_W'($urandom_range(16, 3));
            endcase
            h = ($urandom_range(7) == 0) ? CFG_DATA_W'($urandom_range(2))
                                         : CFG_DATA_W'($urandom_range(8, 3));
            set_w = 1'($urandom_range(1));
            set_h = 1'($urandom_range(1));
            // widen only at a frame start so no unwritten line entry is read
            if (!sb.at_frame_start() &&
                sb.clamp_dim(32'(w[WID_W-1:0]), MAX_WIDTH) > sb.cur_width()) begin
                set_w = 0;
            end
            count = $urandom_range(1) ? 0 : $urandom_range(120, 10);
            run_phase(set_w, w, set_h, h, count);
        end

        drain();
        if (sb.errors == 0) begin
            $display("tb_sobel_edge_magnitude: clean");
        end else begin
            $display("tb_sobel_edge_magnitude: errors");
        end
        $finish;
    end

endmodule
